/* src/sine_tone_generator_core_assert.svh */
// ----------------------------------------------------------------------------
// sine_tone_generator_core_assert.svh
// assertion macros used by the tone generator core
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_GENERATOR_CORE_ASSERT_SVH
`define SINE_TONE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define STG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg
// shared types, constants and the cordic angle table of the tone generator
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int TABLE_LEN  = 24;      // entries in the arctangent table
    localparam int STEP_W     = 5;       // index width for the table
    localparam int TURN_W     = 32;      // normalized phase, one turn = 2^32
    localparam int CORDIC_W   = 34;      // signed q30 datapath with headroom
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int AMP_W      = 15;
    localparam int SAMPLE_W   = 16;

    localparam logic [31:0]         INC_RESET = 32'd42852281;  // 440 hz at 44.1 khz
    localparam logic [AMP_W-1:0]    AMP_RESET = 15'd32767;
    localparam logic [CORDIC_W-1:0] GAIN_Q30  = 34'd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC = 1'b0,
        REG_AMPLITUDE = 1'b1
    } stg_reg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } stg_cordic_status_t;

    // atan(2^-i) in turns, scaled by 2^32
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10680862;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

/* src/sine_tone_generator_core.sv */
// ----------------------------------------------------------------------------
// sine_tone_generator_core
// dds sine oscillator: phase accumulator in ram, iterative cordic sine,
// amplitude scaling with round-to-nearest and int16 saturation
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid s_ready s_action s_start_index | in
//  result  | m_valid m_ready m_sample            | out
//  config  | cfg_wr_en cfg_index cfg_wdata       | in
//
//  samples come from the cordic unit running one micro-rotation per cycle;
//  a new item is taken only in idle, after the last result is loaded
//  reset clears the control state and the phase valid flag and presets the tone registers
//  a stalled m_ready holds the finished sample; the next item is taken
//  and computed meanwhile, waiting only at the final rounding step
// ----------------------------------------------------------------------------
`include "sine_tone_generator_core_assert.svh"

module sine_tone_generator_core #(
    parameter int PHASE_BITS   = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  logic [stg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // input transfer
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic [31:0]                            s_start_index,
    // result transfer
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [stg_pkg::SAMPLE_W-1:0]    m_sample
);
    import stg_pkg::*;

    localparam int NUM_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int EXT_W     = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int PROD_W    = AMP_W + 1 + CORDIC_W;

    localparam logic signed [20:0] SAT_MAX = 21'sd32767;
    localparam logic signed [20:0] SAT_MIN = -21'sd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_ITER,
        S_SCALE,
        S_ROUND
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [31:0]      inc_reg;
    logic [AMP_W-1:0] amp_reg;

    // item and datapath registers
    logic                         act_reg;
    logic [31:0]                  start_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic                         phase_valid_reg;
    logic signed [PROD_W-1:0]     scale_reg;
    logic                         m_valid_reg;
    logic signed [SAMPLE_W-1:0]   m_sample_reg;

    // phase ram
    logic                  ram_re, ram_we;
    logic [PHASE_BITS-1:0] ram_rdata, ram_wdata;

    // cordic
    logic                       cordic_start;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] cordic_y;
    stg_cordic_status_t         cordic_status;

    // combinational datapath
    logic [63:0]               load_prod;
    logic [EXT_W-1:0]          inc_ext;
    logic [TURN_W-1:0]         p_raw, p_fold, p_quarter;
    logic signed [15:0]        amp_s;
    logic signed [PROD_W-1:0]  scale_prod;
    logic signed [PROD_W:0]    rnd_sum, rnd_shift;
    logic signed [20:0]        rnd_val;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic                      out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg <= INC_RESET;
            amp_reg <= AMP_RESET;
        end else if (cfg_wr_en) begin
            case (stg_reg_idx_t'(cfg_index))
                REG_PHASE_INC: inc_reg <= cfg_wdata;
                REG_AMPLITUDE: amp_reg <= cfg_wdata[AMP_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- phase accumulator storage ----------------
    // single entry; until the first write the sequencer uses the reset phase of zero
    stg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (1)
    ) u_phase_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (1'b0),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign ram_re  = s_valid && s_ready;
    // write back happens in setup, the next read not before idle: no overlap
    assign ram_we  = (state_reg == S_SETUP);

    // increment reduced or widened to the accumulator width
    assign inc_ext   = EXT_W'(inc_reg);
    assign ram_wdata = phase_reg + inc_ext[PHASE_BITS-1:0];

    // load product, wraps to the accumulator width
    assign load_prod = 64'(start_reg) * 64'(inc_reg);

    // ---------------- phase to cordic angle ----------------
    generate
        if (PHASE_BITS >= TURN_W) begin : g_phase_wide
            assign p_raw = phase_reg[PHASE_BITS-1 -: TURN_W];
        end else begin : g_phase_narrow
            assign p_raw = {phase_reg, {(TURN_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // fold the second and third quarter onto [-1/4, 1/4] turn
    assign p_quarter = p_raw + 32'h4000_0000;
    assign p_fold    = p_quarter[TURN_W-1] ? (32'h8000_0000 - p_raw) : p_raw;
    assign z_init    = signed'(CORDIC_W'(signed'(p_fold)));

    assign cordic_start = (state_reg == S_SETUP);

    stg_cordic #(
        .NUM_STEPS (NUM_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .z_init  (z_init),
        .y_out   (cordic_y),
        .status  (cordic_status)
    );

    // ---------------- amplitude, rounding, saturation ----------------
    assign amp_s      = signed'({1'b0, amp_reg});
    assign scale_prod = PROD_W'(amp_s * cordic_y);

    // add half an lsb, then floor shift: ties go toward plus infinity
    assign rnd_sum   = {scale_reg[PROD_W-1], scale_reg} + (PROD_W+1)'(64'sd1 <<< 29);
    assign rnd_shift = rnd_sum >>> 30;
    assign rnd_val   = rnd_shift[20:0];

    always_comb begin
        if (rnd_val > SAT_MAX) begin
            sat_val = SAT_MAX[SAMPLE_W-1:0];
        end else if (rnd_val < SAT_MIN) begin
            sat_val = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sat_val = rnd_val[SAMPLE_W-1:0];
        end
    end

    // output register is free when empty or drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // the rounding step refills the output itself when it drains
            if (m_valid_reg && m_ready && (state_reg != S_ROUND)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_action;
                        start_reg <= s_start_index;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // ram data is valid here, in the cycle after the read
                    if (act_reg) begin
                        phase_reg <= load_prod[PHASE_BITS-1:0];
                    end else if (phase_valid_reg) begin
                        phase_reg <= ram_rdata;
                    end else begin
                        phase_reg <= '0;
                    end
                    state_reg <= S_SETUP;
                end
                S_SETUP: begin
                    // advanced phase goes back to ram, cordic starts
                    phase_valid_reg <= 1'b1;
                    state_reg       <= S_ITER;
                end
                S_ITER: begin
                    if (cordic_status.done) begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    scale_reg <= scale_prod;
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= sat_val;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // ---------------- assertions ----------------
    `STG_ASSERT_NOW(a_cordic_in_iter, aclk, aresetn,
        cordic_status.busy || cordic_status.done, state_reg == S_ITER,
        "cordic active outside the iteration state")
    `STG_ASSERT_NEXT(a_accept_reads, aclk, aresetn,
        s_valid && s_ready, state_reg == S_READ && !ram_we,
        "accepted item did not move to the phase read")
    `STG_ASSERT_NOW(a_result_from_round, aclk, aresetn,
        $rose(m_valid_reg), $past(state_reg) == S_ROUND,
        "result loaded outside the rounding state")
    `STG_ASSERT_NOW(a_no_rw_overlap, aclk, aresetn,
        ram_we, !ram_re,
        "phase ram read and write in the same cycle")

endmodule

/* src/stg_ram.sv */
// ----------------------------------------------------------------------------
// stg_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module stg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/stg_cordic.sv */
// ----------------------------------------------------------------------------
// stg_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module stg_cordic #(
    parameter int NUM_STEPS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [stg_pkg::CORDIC_W-1:0]   z_init,
    output logic signed [stg_pkg::CORDIC_W-1:0]   y_out,
    output stg_pkg::stg_cordic_status_t           status
);
    import stg_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
    logic signed [CORDIC_W-1:0] x_sh, y_sh, ang;

    always_comb begin
        x_sh = x_reg >>> step_reg;
        y_sh = y_reg >>> step_reg;
        ang  = signed'(CORDIC_W'(atan_turns(step_reg)));
        if (!z_reg[CORDIC_W-1]) begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= signed'(GAIN_Q30);
            y_reg <= '0;
            z_reg <= z_init;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign y_out       = y_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* test/sine_tone_generator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_core_test
// self-checking bench for the dds sine oscillator: a directed table of
// corner cases, then random phases under several tone settings; samples
// are checked against typed values or a bit-exact cordic predictor in the bench
// ----------------------------------------------------------------------------
module sine_tone_generator_core_test;
    import stg_pkg::*;

    localparam int ROTATIONS      = 16;     // cordic micro-rotations per sample
    localparam int ROW_COUNT      = 24;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transfer

    // arctangent of 2^-i in turns scaled by 2^32
    localparam longint ATAN_TURNS [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint CORDIC_GAIN = 652032874;   // 1/K in q30

    // one row of directed stimulus; sample is used only where typed is set
    typedef struct packed {
        logic               set_cfg;
        logic [31:0]        inc;
        logic [14:0]        amp;
        logic               act;
        logic [31:0]        idx;
        logic               typed;
        logic signed [15:0] sample;
    } tone_row_t;

    typedef struct packed {
        int                 seq;
        logic signed [15:0] sample;
    } tone_expect_t;

    localparam tone_row_t DIRECTED [ROW_COUNT] = '{
        // reset settings: first sample at phase zero, then a plain step
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        // loads with the reset increment, the last two wrap the product
        '{1'b0, 32'h0000_0000, 15'd0,     1'b1, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b1, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b1, 32'h5555_AAAA, 1'b0, 16'sd0},
        // quarter-turn steps walk zero, both peaks and back around
        '{1'b1, 32'h4000_0000, 15'd32767, 1'b1, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        // zero amplitude silences the output whatever the phase
        '{1'b1, 32'h0000_0000, 15'd0,     1'b1, 32'hFFFF_FFFF, 1'b1, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b1, 16'sd0},
        // all-ones increment times all-ones index wraps to one
        '{1'b1, 32'hFFFF_FFFF, 15'd32767, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        // half-turn steps at the smallest amplitude
        '{1'b1, 32'h8000_0000, 15'd1,     1'b1, 32'h0000_0001, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        // eighth-turn steps at half scale
        '{1'b1, 32'h2000_0000, 15'd16384, 1'b1, 32'h0000_0003, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        // just below the quarter-turn fold point and past it
        '{1'b1, 32'h3FFF_FFFF, 15'd32767, 1'b1, 32'h0000_0001, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b1, 32'hC000_0001, 15'd32767, 1'b1, 32'h0000_0001, 1'b0, 16'sd0},
        // frozen phase at exact zero
        '{1'b1, 32'h0000_0000, 15'd32767, 1'b1, 32'h0000_0000, 1'b0, 16'sd0},
        '{1'b0, 32'h0000_0000, 15'd0,     1'b0, 32'h0000_0000, 1'b0, 16'sd0}
    };

    // dut ports; the driven inputs are known from time zero
    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic                    s_action      = 1'b0;
    logic [31:0]             s_start_index = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;

    // predictor state: our own copy of the accumulator and the tone settings
    logic [31:0]  tone_phase = '0;
    logic [31:0]  tone_inc   = INC_RESET;
    logic [14:0]  tone_amp   = AMP_RESET;

    tone_expect_t pending_samples [$];
    tone_expect_t head_expect;
    int           accepted     = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    int           stall_left   = 0;
    bit           calm         = 1'b0;   // no idling on either side while set

    sine_tone_generator_core #(
        .PHASE_BITS   (32),
        .CORDIC_STEPS (ROTATIONS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_start_index (s_start_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // lower valid and let every pending sample drain, so the block is idle
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
    endtask

    // write both tone registers back to back, only while idle
    task automatic program_tone(input logic [31:0] inc, input logic [14:0] amp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PHASE_INC;
        cfg_wdata <= inc;
        @(posedge aclk);
        cfg_index <= REG_AMPLITUDE;
        cfg_wdata <= {{(CFG_DATA_W-AMP_W){1'b0}}, amp};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tone_inc = inc;
        tone_amp = amp;
    endtask

    // offer one item, wait for its transfer, then predict its sample
    task automatic send_item(input logic act, input logic [31:0] idx,
                             input logic typed, input logic signed [15:0] typed_sample);
        int           gap;
        logic [31:0]  folded;
        logic [31:0]  shifted;
        longint       x, y, z, nx, amp_l, v;
        tone_expect_t entry;

        // random idle ahead of the item, now and then a long one
        gap = 0;
        while (!calm && $urandom_range(99) < 38) gap++;
        if (!calm && $urandom_range(19) == 0) gap += $urandom_range(40, 1);
        if (gap > 0) begin
            s_valid       <= 1'b0;
            s_action      <= 1'($urandom);
            s_start_index <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_start_index <= idx;
        do @(posedge aclk); while (!s_ready);

        // load: phase becomes start index times increment, wrapped to 32 bits
        if (act) tone_phase = idx * tone_inc;

        // fold into [-1/4, +1/4] turn using sin(t) = sin(1/2 - t)
        folded  = tone_phase;
        shifted = tone_phase + 32'h4000_0000;
        if (shifted[31]) folded = 32'h8000_0000 - tone_phase;
        z = $signed(folded);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < ROTATIONS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end
            x = nx;
        end

        // scale, round half up, then clamp to int16
        amp_l = tone_amp;
        v = (amp_l * y + 64'sd536870912) >>> 30;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;

        tone_phase   = tone_phase + tone_inc;
        entry.seq    = accepted;
        entry.sample = typed ? typed_sample : v[15:0];
        accepted++;
        pending_samples.push_back(entry);
    endtask

    // result side: check each transfer and pick the next ready level
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with nothing pending", m_sample));
                end else begin
                    head_expect = pending_samples.pop_front();
                    if (m_sample !== head_expect.sample)
                        report_mismatch($sformatf("item %0d sample %0d, predicted %0d",
                                                  head_expect.seq, m_sample,
                                                  head_expect.sample));
                end
            end
            if (calm) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                // long back-pressure holds a finished sample at the output
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if ($urandom_range(99) < 2) begin
                stall_left <= $urandom_range(40, 5);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= 38);
            end
        end
    end

    // watchdog: too long with no transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] inc;
        logic [14:0] amp;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; rows that change settings drain first
        for (int k = 0; k < ROW_COUNT; k++) begin
            if (DIRECTED[k].set_cfg) begin
                wait_quiet();
                program_tone(DIRECTED[k].inc, DIRECTED[k].amp);
            end
            send_item(DIRECTED[k].act, DIRECTED[k].idx,
                      DIRECTED[k].typed, DIRECTED[k].sample);
        end

        // random phases, each under its own tone settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_quiet();
            case (ph % 4)
                0:       inc = $urandom;
                1:       inc = $urandom_range(32'h0100_0000, 0);       // audio-like pitch
                2:       inc = 32'hFFFF_FFFF - $urandom_range(1000, 0); // near full turn
                default: inc = $urandom_range(8, 0);                    // nearly frozen
            endcase
            case (ph)
                1:       amp = 15'd32767;
                5:       amp = 15'd0;
                6:       amp = 15'd1;
                default: amp = 15'($urandom_range(32767, 0));
            endcase
            program_tone(inc, amp);
            calm = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(($urandom_range(7) == 0), $urandom, 1'b0, 16'sd0);
        end
        calm = 1'b0;

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
